// ===== design/jsu_pkg.sv =====
package jsu_pkg;

    localparam int MAX_RES = 5;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_TEXT  = 4'd1,
        M_ESC   = 4'd2,
        M_HEX   = 4'd3,
        M_WIN   = 4'd4,
        M_DRAIN = 4'd5
    } t_mode;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_NO_OPEN    = 4'd1;
    localparam logic [3:0] ERR_CTRL       = 4'd2;
    localparam logic [3:0] ERR_ESC_TRUNC  = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC    = 4'd4;
    localparam logic [3:0] ERR_UNI_TRUNC  = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX    = 4'd6;
    localparam logic [3:0] ERR_HI_UNPAIR  = 4'd7;
    localparam logic [3:0] ERR_BAD_LO     = 4'd8;
    localparam logic [3:0] ERR_LONE_LO    = 4'd9;
    localparam logic [3:0] ERR_UNTERM     = 4'd10;

    localparam logic [1:0] WF_NONE    = 2'd0;
    localparam logic [1:0] WF_UNPAIR  = 2'd1;
    localparam logic [1:0] WF_BAD_HEX = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] SUR_HI_LO = 16'hd800;
    localparam logic [15:0] SUR_HI_HI = 16'hdbff;
    localparam logic [15:0] SUR_LO_LO = 16'hdc00;
    localparam logic [15:0] SUR_LO_HI = 16'hdfff;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } t_enc;

    // 16 = not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b inside {[8'h30:8'h39]}) begin
            v = 5'(b - 8'h30);
        end else if (b inside {[8'h61:8'h66]}) begin
            v = 5'(b - 8'h57);
        end else if (b inside {[8'h41:8'h46]}) begin
            v = 5'(b - 8'h37);
        end
        return v;
    endfunction

    function automatic t_enc utf8_encode(input logic [20:0] cp);
        t_enc e;
        e.bytes = '0;
        if (cp <= 21'h7f) begin
            e.cnt = 3'd1;
            e.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            e.cnt = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            e.cnt = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            e.cnt = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ===== design/json_string_unescape_utf8_core.sv =====
// channel | valid       | ready       | payload
// input   | i_in_valid  | o_in_ready  | i_in_byte, i_in_final
// output  | o_out_valid | i_out_ready | o_out_kind, o_out_data, o_error_code, o_out_last
//
// One input byte per cycle when each byte gives at most one word and the output is not stalled.
// A byte that gives n words (up to 5: a 4-byte UTF-8 sequence and an error)
// holds the input while the result buffer drains.
// Decoding is done at accept time; the result buffer is the only output stage.
// Reset (synchronous, active low) returns to waiting for an opening quote.
// Output stalls back up into the input only through the result buffer.
module json_string_unescape_utf8_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_data,
    output logic [3:0] o_error_code,
    output logic       o_out_last
);
    import jsu_pkg::*;

    t_mode r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [2:0]  r_dcnt, n_dcnt;
    logic [9:0]  r_hh, n_hh;
    logic [1:0]  r_wf, n_wf;

    logic [1:0] r_kind [MAX_RES];
    logic [7:0] r_data [MAX_RES];
    logic [3:0] r_code [MAX_RES];
    logic [RES_CNT_W-1:0] r_cnt;
    logic [RES_IDX_W-1:0] r_idx;

    logic accept;
    logic fin;
    logic [7:0] b;
    logic [4:0] hv;
    logic [15:0] acc;
    logic [2:0] cnt;
    logic [1:0] wf;
    logic [20:0] cp;
    t_enc enc;
    logic use_enc;
    logic [2:0] nd;
    logic [7:0] d0;
    logic do_fail;
    logic do_close;
    logic [3:0] fcode;
    logic [RES_CNT_W-1:0] nres;
    logic [15:0] lo_off;

    assign b   = i_in_byte;
    assign fin = i_in_final;

    always_comb begin
        n_mode   = r_mode;
        n_hex    = r_hex;
        n_dcnt   = r_dcnt;
        n_hh     = r_hh;
        n_wf     = r_wf;
        hv       = hex_value(b);
        acc      = r_hex;
        cnt      = r_dcnt + 3'd1;
        wf       = r_wf;
        cp       = '0;
        use_enc  = 1'b0;
        nd       = 3'd0;
        d0       = b;
        do_fail  = 1'b0;
        do_close = 1'b0;
        fcode    = ERR_NONE;
        lo_off   = '0;
        case (r_mode)
            M_IDLE: begin
                if (b != CH_QUOTE) begin
                    do_fail = 1'b1;
                    fcode = ERR_NO_OPEN;
                end else if (fin) begin
                    do_fail = 1'b1;
                    fcode = ERR_UNTERM;
                end else begin
                    n_mode = M_TEXT;
                end
            end
            M_TEXT: begin
                if (b == CH_QUOTE) begin
                    do_close = 1'b1;
                    n_mode = M_IDLE;
                end else if (b < CH_SPACE) begin
                    do_fail = 1'b1;
                    fcode = ERR_CTRL;
                end else if (b == CH_BSL) begin
                    if (fin) begin
                        do_fail = 1'b1;
                        fcode = ERR_ESC_TRUNC;
                    end else begin
                        n_mode = M_ESC;
                    end
                end else begin
                    nd = 3'd1;
                    if (fin) begin
                        do_fail = 1'b1;
                        fcode = ERR_UNTERM;
                    end
                end
            end
            M_ESC: begin
                if (b == CH_U) begin
                    n_hex  = '0;
                    n_dcnt = '0;
                    n_hh   = '0;
                    n_wf   = WF_NONE;
                    n_mode = M_HEX;
                    if (fin) begin
                        do_fail = 1'b1;
                        fcode = ERR_UNI_TRUNC;
                    end
                end else begin
                    nd = 3'd1;
                    case (b)
                        CH_QUOTE, CH_BSL, CH_SLASH: d0 = b;
                        CH_B:    d0 = 8'h08;
                        CH_F:    d0 = 8'h0c;
                        CH_N:    d0 = 8'h0a;
                        CH_R:    d0 = 8'h0d;
                        CH_T:    d0 = 8'h09;
                        default: nd = 3'd0;
                    endcase
                    if (nd == 3'd0) begin
                        do_fail = 1'b1;
                        fcode = ERR_BAD_ESC;
                    end else begin
                        n_mode = M_TEXT;
                        if (fin) begin
                            do_fail = 1'b1;
                            fcode = ERR_UNTERM;
                        end
                    end
                end
            end
            M_HEX: begin
                acc = {r_hex[11:0], hv[3:0]};
                if (hv[4]) begin
                    do_fail = 1'b1;
                    fcode = ERR_BAD_HEX;
                end else if (cnt < 3'd4) begin
                    n_hex  = acc;
                    n_dcnt = cnt;
                    if (fin) begin
                        do_fail = 1'b1;
                        fcode = ERR_UNI_TRUNC;
                    end
                end else if (acc >= SUR_HI_LO && acc <= SUR_HI_HI) begin
                    if (fin) begin
                        do_fail = 1'b1;
                        fcode = ERR_HI_UNPAIR;
                    end else begin
                        n_hex  = '0;
                        n_dcnt = '0;
                        n_wf   = WF_NONE;
                        n_hh   = acc[9:0];
                        n_mode = M_WIN;
                    end
                end else if (acc >= SUR_LO_LO && acc <= SUR_LO_HI) begin
                    do_fail = 1'b1;
                    fcode = ERR_LONE_LO;
                end else begin
                    cp      = {5'd0, acc};
                    use_enc = 1'b1;
                    n_hex   = '0;
                    n_dcnt  = '0;
                    n_hh    = '0;
                    n_wf    = WF_NONE;
                    n_mode  = M_TEXT;
                    if (fin) begin
                        do_fail = 1'b1;
                        fcode = ERR_UNTERM;
                    end
                end
            end
            M_WIN: begin
                // first fault in the window is latched and reported at its end
                if (r_wf == WF_NONE) begin
                    if (r_dcnt == 3'd0 && b != CH_BSL) begin
                        wf = WF_UNPAIR;
                    end else if (r_dcnt == 3'd1 && b != CH_U) begin
                        wf = WF_UNPAIR;
                    end else if (r_dcnt >= 3'd2) begin
                        if (hv[4]) begin
                            wf = WF_BAD_HEX;
                        end else begin
                            acc = {r_hex[11:0], hv[3:0]};
                        end
                    end
                end
                if (cnt < 3'd6) begin
                    n_wf   = wf;
                    n_hex  = acc;
                    n_dcnt = cnt;
                    if (fin) begin
                        do_fail = 1'b1;
                        fcode = ERR_HI_UNPAIR;
                    end
                end else if (wf == WF_UNPAIR) begin
                    do_fail = 1'b1;
                    fcode = ERR_HI_UNPAIR;
                end else if (wf != WF_NONE) begin
                    do_fail = 1'b1;
                    fcode = ERR_BAD_HEX;
                end else if (acc < SUR_LO_LO || acc > SUR_LO_HI) begin
                    do_fail = 1'b1;
                    fcode = ERR_BAD_LO;
                end else begin
                    // 0x10000 + (hh << 10) + low offset
                    lo_off  = acc - SUR_LO_LO;
                    cp      = {11'(r_hh) + 11'd64, lo_off[9:0]};
                    use_enc = 1'b1;
                    n_hex   = '0;
                    n_dcnt  = '0;
                    n_hh    = '0;
                    n_wf    = WF_NONE;
                    n_mode  = M_TEXT;
                    if (fin) begin
                        do_fail = 1'b1;
                        fcode = ERR_UNTERM;
                    end
                end
            end
            M_DRAIN: begin
                if (fin) begin
                    n_mode = M_IDLE;
                end
            end
            default: begin
                n_mode = M_IDLE;
                n_hex  = '0;
                n_dcnt = '0;
                n_hh   = '0;
                n_wf   = WF_NONE;
            end
        endcase
        enc = utf8_encode(cp);
        if (use_enc) begin
            nd = enc.cnt;
        end else begin
            enc.bytes[0] = d0;
        end
        if (do_fail) begin
            n_mode = fin ? M_IDLE : M_DRAIN;
            n_hex  = '0;
            n_dcnt = '0;
            n_hh   = '0;
            n_wf   = WF_NONE;
        end
        nres = RES_CNT_W'(nd) + RES_CNT_W'(do_fail || do_close);
    end

    // input is taken when the buffer is empty or its last word leaves now
    assign o_out_valid = (RES_CNT_W'(r_idx) != r_cnt);
    assign o_out_last  = (RES_CNT_W'(r_idx) == r_cnt - RES_CNT_W'(1));
    assign o_in_ready  = !o_out_valid || (i_out_ready && o_out_last);
    assign accept      = i_in_valid && o_in_ready;

    assign o_out_kind   = r_kind[r_idx];
    assign o_out_data   = r_data[r_idx];
    assign o_error_code = r_code[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hex  <= '0;
            r_dcnt <= '0;
            r_hh   <= '0;
            r_wf   <= WF_NONE;
            r_cnt  <= '0;
            r_idx  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_dcnt <= n_dcnt;
            r_hh   <= n_hh;
            r_wf   <= n_wf;
            r_cnt  <= nres;
            r_idx  <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_idx <= r_idx + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (k < int'(nd)) begin
                    r_kind[k] <= KIND_DATA;
                    r_data[k] <= (k < 4) ? enc.bytes[k[1:0]] : 8'd0;
                    r_code[k] <= ERR_NONE;
                end else begin
                    r_kind[k] <= do_fail ? KIND_ERR : KIND_CLOSE;
                    r_data[k] <= 8'd0;
                    r_code[k] <= do_fail ? fcode : ERR_NONE;
                end
            end
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        RES_CNT_W'(r_idx) <= r_cnt)
        else $error("result index past count");

    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind != KIND_DATA |-> o_out_last)
        else $error("close or error word not last");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_last |=> o_out_valid)
        else $error("burst ended before last word");

    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_mode == M_DRAIN |=> !o_out_valid)
        else $error("word produced while draining");

    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind != KIND_DATA |-> o_out_data == 8'd0)
        else $error("nonzero data on non-data word");

endmodule

// ===== tb/json_unescape_checker.sv =====
module json_unescape_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_out_kind,
    input  logic [7:0] i_out_data,
    input  logic [3:0] i_error_code,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_taken,
    output int         o_words,
    output logic [10:0] o_code_mask
);
    import jsu_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] code;
        logic       last;
    } t_word;

    t_word expected_words[$];
    t_word step_words[$];

    // decoder state mirror
    t_mode       mode;
    logic [15:0] hex_acc;
    logic [2:0]  dig_cnt;
    logic [9:0]  hi_half;
    logic [1:0]  win_fault;

    int          fails;
    int          taken;
    int          words;
    logic [10:0] code_mask;

    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 8'd10);
        if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 8'd10);
        return 5'h10;
    endfunction

    task automatic stage_word(input t_word w);
        step_words.insert(step_words.size(), w);
    endtask

    task automatic queue_expected(input t_word w);
        expected_words.insert(expected_words.size(), w);
    endtask

    task automatic clear_work();
        hex_acc   = '0;
        dig_cnt   = '0;
        hi_half   = '0;
        win_fault = WF_NONE;
    endtask

    task automatic add_word(input logic [1:0] kind, input logic [7:0] data,
                            input logic [3:0] code);
        t_word w;
        w = '{kind: kind, data: data, code: code, last: 1'b0};
        stage_word(w);
    endtask

    task automatic raise_err(input logic [3:0] code, input logic fin);
        add_word(KIND_ERR, 8'h00, code);
        mode = fin ? M_IDLE : M_DRAIN;
        clear_work();
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        int         n;
        logic [7:0] lead;
        n = (cp <= 21'h7f) ? 1 : (cp <= 21'h7ff) ? 2 : (cp <= 21'hffff) ? 3 : 4;
        if (n == 1) begin
            add_word(KIND_DATA, cp[7:0], ERR_NONE);
        end else begin
            lead = 8'hff << (8 - n);
            add_word(KIND_DATA, lead | 8'(cp >> (6 * (n - 1))), ERR_NONE);
            for (int k = n - 2; k >= 0; k--)
                add_word(KIND_DATA, 8'h80 | 8'((cp >> (6 * k)) & 21'h3f), ERR_NONE);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [4:0]  v;
        logic [7:0]  esc;
        logic        bad;
        logic [15:0] cp16;
        logic [20:0] cp;
        t_word       w;
        step_words.delete();
        case (mode)
            M_IDLE: begin
                if (b != CH_QUOTE) raise_err(ERR_NO_OPEN, fin);
                else if (fin) raise_err(ERR_UNTERM, fin);
                else mode = M_TEXT;
            end
            M_TEXT: begin
                if (b == CH_QUOTE) begin
                    add_word(KIND_CLOSE, 8'h00, ERR_NONE);
                    mode = M_IDLE;
                end else if (b < CH_SPACE) begin
                    raise_err(ERR_CTRL, fin);
                end else if (b == CH_BSL) begin
                    if (fin) raise_err(ERR_ESC_TRUNC, fin);
                    else mode = M_ESC;
                end else begin
                    add_word(KIND_DATA, b, ERR_NONE);
                    if (fin) raise_err(ERR_UNTERM, fin);
                end
            end
            M_ESC: begin
                if (b == CH_U) begin
                    clear_work();
                    mode = M_HEX;
                    if (fin) raise_err(ERR_UNI_TRUNC, fin);
                end else begin
                    bad = 1'b0;
                    esc = b;
                    case (b)
                        CH_QUOTE, CH_BSL, CH_SLASH: esc = b;
                        CH_B:    esc = 8'h08;
                        CH_F:    esc = 8'h0c;
                        CH_N:    esc = 8'h0a;
                        CH_R:    esc = 8'h0d;
                        CH_T:    esc = 8'h09;
                        default: bad = 1'b1;
                    endcase
                    if (bad) begin
                        raise_err(ERR_BAD_ESC, fin);
                    end else begin
                        add_word(KIND_DATA, esc, ERR_NONE);
                        mode = M_TEXT;
                        if (fin) raise_err(ERR_UNTERM, fin);
                    end
                end
            end
            M_HEX: begin
                v = nibble_of(b);
                if (v[4]) begin
                    raise_err(ERR_BAD_HEX, fin);
                end else begin
                    hex_acc = {hex_acc[11:0], v[3:0]};
                    dig_cnt = dig_cnt + 3'd1;
                    if (dig_cnt < 3'd4) begin
                        if (fin) raise_err(ERR_UNI_TRUNC, fin);
                    end else begin
                        cp16 = hex_acc;
                        if (cp16 >= SUR_HI_LO && cp16 <= SUR_HI_HI) begin
                            if (fin) begin
                                raise_err(ERR_HI_UNPAIR, fin);
                            end else begin
                                clear_work();
                                hi_half = 10'(cp16 - SUR_HI_LO);
                                mode = M_WIN;
                            end
                        end else if (cp16 >= SUR_LO_LO && cp16 <= SUR_LO_HI) begin
                            raise_err(ERR_LONE_LO, fin);
                        end else begin
                            emit_utf8(21'(cp16));
                            clear_work();
                            mode = M_TEXT;
                            if (fin) raise_err(ERR_UNTERM, fin);
                        end
                    end
                end
            end
            M_WIN: begin
                // window = the six bytes of the expected low surrogate escape \uDC00-\uDFFF; first fault wins
                if (win_fault == WF_NONE) begin
                    if (dig_cnt == 3'd0 && b != CH_BSL) begin
                        win_fault = WF_UNPAIR;
                    end else if (dig_cnt == 3'd1 && b != CH_U) begin
                        win_fault = WF_UNPAIR;
                    end else if (dig_cnt >= 3'd2) begin
                        v = nibble_of(b);
                        if (v[4]) win_fault = WF_BAD_HEX;
                        else hex_acc = {hex_acc[11:0], v[3:0]};
                    end
                end
                dig_cnt = dig_cnt + 3'd1;
                if (dig_cnt < 3'd6) begin
                    if (fin) raise_err(ERR_HI_UNPAIR, fin);
                end else if (win_fault == WF_UNPAIR) begin
                    raise_err(ERR_HI_UNPAIR, fin);
                end else if (win_fault != WF_NONE) begin
                    raise_err(ERR_BAD_HEX, fin);
                end else if (hex_acc < SUR_LO_LO || hex_acc > SUR_LO_HI) begin
                    raise_err(ERR_BAD_LO, fin);
                end else begin
                    cp = 21'h10000 + {1'b0, hi_half, 10'b0} + 21'(hex_acc - SUR_LO_LO);
                    emit_utf8(cp);
                    clear_work();
                    mode = M_TEXT;
                    if (fin) raise_err(ERR_UNTERM, fin);
                end
            end
            M_DRAIN: begin
                if (fin) mode = M_IDLE;
            end
            default: begin
                mode = M_IDLE;
                clear_work();
            end
        endcase
        if (step_words.size() > 0) begin
            w = step_words.pop_back();
            w.last = 1'b1;
            stage_word(w);
        end
        foreach (step_words[i]) queue_expected(step_words[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (fails < 40)
            $display("MISMATCH at word %0d: %s got 0x%0h want 0x%0h", words, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            mode = M_IDLE;
            clear_work();
            expected_words.delete();
            fails     = 0;
            taken     = 0;
            words     = 0;
            code_mask = '0;
        end else begin
            // check before predicting: a word can never leave on the edge its byte enters
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, kind", 8'(i_out_kind), 8'h00);
                end else begin
                    w = expected_words.pop_front();
                    if (i_out_kind != w.kind)
                        report_mismatch("kind", 8'(i_out_kind), 8'(w.kind));
                    if (i_out_data != w.data)
                        report_mismatch("data", i_out_data, w.data);
                    if (i_error_code != w.code)
                        report_mismatch("error code", 8'(i_error_code), 8'(w.code));
                    if (i_out_last != w.last)
                        report_mismatch("last", 8'(i_out_last), 8'(w.last));
                end
                if (i_out_kind == KIND_ERR && i_error_code <= ERR_UNTERM)
                    code_mask[i_error_code] = 1'b1;
                words++;
            end
            if (i_in_valid && i_in_ready) begin
                taken++;
                decode_byte(i_in_byte, i_in_final);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
        o_taken      <= taken;
        o_words      <= words;
        o_code_mask  <= code_mask;
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import jsu_pkg::*;

    localparam int NUM_BYTES   = 420;
    localparam int CALM_TAIL   = 60;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_in_final;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_out_data;
    logic [3:0]  o_error_code;
    logic        o_out_last;

    int          fail_count;
    int          pending;
    int          taken;
    int          words;
    logic [10:0] code_mask;

    logic [7:0]  src[$];
    logic [7:0]  win[6];
    int          gap_pct;
    bit          calm;
    int          quiet_cycles;

    json_string_unescape_utf8_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_final   (i_in_final),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_kind   (o_out_kind),
        .o_out_data   (o_out_data),
        .o_error_code (o_error_code),
        .o_out_last   (o_out_last)
    );

    json_unescape_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_final   (i_in_final),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_kind   (o_out_kind),
        .i_out_data   (o_out_data),
        .i_error_code (o_error_code),
        .i_out_last   (o_out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_taken      (taken),
        .o_words      (words),
        .o_code_mask  (code_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // --- source text builders ---

    task automatic put_src(input logic [7:0] b);
        src.insert(src.size(), b);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] not_hex();
        case ($urandom_range(0, 7))
            0: return 8'h67;
            1: return 8'h47;
            2: return 8'h2f;
            3: return 8'h3a;
            4: return 8'h40;
            5: return 8'h60;
            6: return 8'h00;
            default: return 8'hff;
        endcase
    endfunction

    function automatic logic [7:0] simple_esc();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSL;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h20, 8'hff));
        while (b == CH_QUOTE || b == CH_BSL);
        return b;
    endfunction

    function automatic logic [7:0] bad_esc_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        return b;
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] x);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == x);
        return b;
    endfunction

    function automatic logic [15:0] pick16(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0: return 16'(lo);
            1: return 16'(hi);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) put_src(s[i]);
    endtask

    task automatic add_u(input logic [15:0] val);
        put_src(CH_BSL);
        put_src(CH_U);
        for (int i = 3; i >= 0; i--) put_src(hex_char(val[i*4 +: 4]));
    endtask

    task automatic spoil_win(input int p);
        if (p == 0) win[0] = byte_other_than(CH_BSL);
        else if (p == 1) win[1] = byte_other_than(CH_U);
        else win[p] = not_hex();
    endtask

    task automatic add_good_token();
        logic [15:0] val;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: put_src(plain_char());
            4, 5: begin
                put_src(CH_BSL);
                put_src(simple_esc());
            end
            6: add_u(pick16(16'h0000, 16'h007f));
            7: add_u(pick16(16'h0080, 16'h07ff));
            8: begin
                val = pick16(16'h0800, 16'hffff);
                if (val >= SUR_HI_LO && val <= SUR_LO_HI) val = val + 16'h2000;
                add_u(val);
            end
            default: begin
                add_u(pick16(SUR_HI_LO, SUR_HI_HI));
                add_u(pick16(SUR_LO_LO, SUR_LO_HI));
            end
        endcase
    endtask

    task automatic add_bad_token();
        logic [15:0] val;
        int          p;
        case ($urandom_range(0, 7))
            0: put_src(8'($urandom_range(0, 31)));
            1: begin
                put_src(CH_BSL);
                put_src(bad_esc_char());
            end
            2: begin
                put_src(CH_BSL);
                put_src(CH_U);
                repeat ($urandom_range(0, 3)) put_src(hex_char(4'($urandom)));
                put_src(not_hex());
            end
            3: add_u(pick16(SUR_LO_LO, SUR_LO_HI));
            default: begin
                // high surrogate followed by a damaged low-surrogate window
                add_u(pick16(SUR_HI_LO, SUR_HI_HI));
                val = pick16(SUR_LO_LO, SUR_LO_HI);
                win[0] = CH_BSL;
                win[1] = CH_U;
                for (int i = 0; i < 4; i++) win[2 + i] = hex_char(val[(3 - i)*4 +: 4]);
                p = $urandom_range(0, 6);
                if (p == 6) begin
                    val = 16'($urandom);
                    if (val >= SUR_LO_LO && val <= SUR_LO_HI) val = val ^ 16'h8000;
                    for (int i = 0; i < 4; i++) win[2 + i] = hex_char(val[(3 - i)*4 +: 4]);
                end else begin
                    spoil_win(p);
                    if ($urandom_range(0, 2) == 0) spoil_win($urandom_range(p, 5));
                end
                foreach (win[i]) put_src(win[i]);
            end
        endcase
    endtask

    task automatic build_source();
        int st;
        int nstr;
        int keep;
        st = $urandom_range(0, 99);
        if (st < 8) begin
            repeat ($urandom_range(1, 5)) put_src(8'($urandom_range(0, 255)));
        end else if (st < 14) begin
            // source ends on a high surrogate or inside its window
            put_src(CH_QUOTE);
            add_u(pick16(SUR_HI_LO, SUR_HI_HI));
            add_u(pick16(SUR_LO_LO, SUR_LO_HI));
            repeat ($urandom_range(1, 6)) void'(src.pop_back());
        end else begin
            nstr = $urandom_range(1, 2);
            for (int s = 0; s < nstr; s++) begin
                put_src(CH_QUOTE);
                repeat ($urandom_range(0, 8)) begin
                    if ($urandom_range(0, 99) < 10) add_bad_token();
                    else add_good_token();
                end
                if (s < nstr - 1 || $urandom_range(0, 9) != 0) put_src(CH_QUOTE);
            end
            if (st < 26) begin
                keep = $urandom_range(1, src.size());
                while (src.size() > keep) void'(src.pop_back());
            end
        end
    endtask

    // --- handshakes ---

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_final <= fin;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_source();
        for (int i = 0; i < src.size(); i++) send_byte(src[i], i == src.size() - 1);
        src.delete();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // output side: random stall bursts, stall rate changes over the run
    initial begin
        int stall_pct;
        int phase_left;
        stall_pct  = 0;
        phase_left = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    default: stall_pct = 25;
                endcase
                phase_left = $urandom_range(20, 100);
            end
            phase_left--;
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // watchdog: cycles in which neither channel moves a word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        calm         = 1'b0;
        gap_pct      = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_byte  <= 8'h00;
        i_in_final <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, idle errors, escape truncations, text errors
        put_src(8'hff);
        send_source();
        add_str("\"");
        send_source();
        put_src(8'h00);
        put_src(CH_QUOTE);
        send_source();
        add_str("\"a");
        send_source();
        add_str("\"\\");
        send_source();
        add_str("\"\\u");
        send_source();
        add_str("\"\\uD800");
        send_source();
        put_src(CH_QUOTE);
        put_src(8'h1f);
        send_source();
        add_str("\"\\q\"");
        send_source();
        wait_drained();

        while (taken < NUM_BYTES) begin
            case ($urandom_range(0, 3))
                0, 1: gap_pct = 0;
                2: gap_pct = 8;
                default: gap_pct = 30;
            endcase
            if (taken >= NUM_BYTES - CALM_TAIL) calm = 1'b1;
            build_source();
            send_source();
            if (!calm && $urandom_range(0, 19) == 0) wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d source bytes and %0d checked output words.",
                 taken, words);
        $display("Error codes seen (bit n = code n): %b", code_mask);
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
